// ===== design/acg_pkg.sv =====
`default_nettype none
package acg_pkg;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_CHECK  = 3'd1;
    localparam logic [2:0] KIND_RECORD = 3'd2;
    localparam logic [2:0] KIND_GUARDS = 3'd3;
    localparam logic [2:0] KIND_LOCK   = 3'd4;
    localparam logic [2:0] KIND_REMOVE = 3'd5;

    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_UNKNOWN  = 3'd1;
    localparam logic [2:0] VERDICT_BOUND    = 3'd2;
    localparam logic [2:0] VERDICT_LOCKOUT  = 3'd3;
    localparam logic [2:0] VERDICT_COOLDOWN = 3'd4;
    localparam logic [2:0] VERDICT_RATE     = 3'd5;

    localparam logic [1:0] SRC_RULE   = 2'd0;
    localparam logic [1:0] SRC_SAFETY = 2'd2;

    localparam logic [7:0]  COUNT_MAX      = 8'hFF;
    localparam logic [15:0] WINDOW_DEFAULT = 16'd3600;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  device_index;
        logic [7:0]  action_code;
        logic        action_known;
        logic [15:0] firmware_bound;
        logic [15:0] param_value;
        logic [7:0]  action_flags;
        logic [15:0] cooldown_seconds;
        logic [7:0]  hourly_limit;
        logic        lockout_on;
        logic [1:0]  source;
        logic [31:0] now_seconds;
    } item_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture input item
        logic search;  // register row and slot search
        logic apply;   // perform state update and form result
    } cmd_t;

endpackage
`default_nettype wire

// ===== design/acg_datapath.sv =====
`default_nettype none
module acg_datapath
    import acg_pkg::*;
#(
    parameter int DEVICE_ROWS   = 8,
    parameter int SLOTS_PER_ROW = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire item_t       item_in,
    input  wire logic [15:0] window_length,
    output logic             success,
    output logic [2:0]       verdict,
    output logic [31:0]      drop_count
);
    localparam int RW = (DEVICE_ROWS > 1) ? $clog2(DEVICE_ROWS) : 1;
    localparam int SW = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;

    logic [DEVICE_ROWS-1:0]  row_valid_reg;
    logic [7:0]              row_device_reg [DEVICE_ROWS];
    logic [DEVICE_ROWS-1:0]  row_lockout_reg;
    logic [7:0]  slot_action_reg [DEVICE_ROWS][SLOTS_PER_ROW];
    logic [7:0]  slot_flags_reg  [DEVICE_ROWS][SLOTS_PER_ROW];
    logic [15:0] slot_bound_reg  [DEVICE_ROWS][SLOTS_PER_ROW];
    logic [15:0] slot_cool_reg   [DEVICE_ROWS][SLOTS_PER_ROW];
    logic [7:0]  slot_limit_reg  [DEVICE_ROWS][SLOTS_PER_ROW];
    logic [7:0]  slot_count_reg  [DEVICE_ROWS][SLOTS_PER_ROW];
    logic [31:0] slot_last_reg   [DEVICE_ROWS][SLOTS_PER_ROW];
    logic [31:0] slot_start_reg  [DEVICE_ROWS][SLOTS_PER_ROW];
    logic [31:0] drop_reg;

    item_t       item_reg;
    logic        rhit_reg, rfree_ok_reg;
    logic [RW-1:0] rhit_idx_reg, rfree_idx_reg;

    // stage 1: row search
    logic          rhit, rfree_ok;
    logic [RW-1:0] rhit_idx, rfree_idx;
    always_comb
    begin
        rhit = 1'b0; rhit_idx = '0; rfree_ok = 1'b0; rfree_idx = '0;
        for (int i = DEVICE_ROWS - 1; i >= 0; i--)
        begin
            if (row_valid_reg[i] && row_device_reg[i] == item_reg.device_index)
            begin
                rhit = 1'b1; rhit_idx = RW'(i);
            end
            if (!row_valid_reg[i])
            begin
                rfree_ok = 1'b1; rfree_idx = RW'(i);
            end
        end
    end

    // stage 2: slot search in the chosen row
    logic [RW-1:0] r;
    logic          shit, sfree_ok;
    logic [SW-1:0] s, sfree;
    always_comb
    begin
        r = rhit_reg ? rhit_idx_reg : rfree_idx_reg;
        shit = 1'b0; s = '0; sfree_ok = 1'b0; sfree = '0;
        for (int j = SLOTS_PER_ROW - 1; j >= 0; j--)
        begin
            if (rhit_reg && item_reg.action_code != 8'd0
                && slot_action_reg[rhit_idx_reg][j] == item_reg.action_code)
            begin
                shit = 1'b1; s = SW'(j);
            end
            if (!rhit_reg || slot_action_reg[rhit_idx_reg][j] == 8'd0)
            begin
                sfree_ok = 1'b1; sfree = SW'(j);
            end
        end
    end

    logic          shit_reg, sfree_ok_reg;
    logic [SW-1:0] s_reg;
    logic [RW-1:0] r_reg;
    logic [7:0]  c_count, c_limit;
    logic [15:0] c_cool, c_bound;
    logic [31:0] c_last, c_start, d_start, d_last;
    logic        c_lock;

    // fetch of the selected slot
    always_comb
    begin
        c_count = slot_count_reg[r_reg][s_reg];
        c_limit = slot_limit_reg[r_reg][s_reg];
        c_cool  = slot_cool_reg[r_reg][s_reg];
        c_bound = slot_bound_reg[r_reg][s_reg];
        c_last  = slot_last_reg[r_reg][s_reg];
        c_start = slot_start_reg[r_reg][s_reg];
        c_lock  = row_lockout_reg[r_reg];
        d_start = item_reg.now_seconds - c_start;
        d_last  = item_reg.now_seconds - c_last;
    end

    logic back_win, window_live, in_cool;
    logic [2:0] chk;
    always_comb
    begin
        back_win = item_reg.now_seconds < c_start;
        window_live = (c_count != 8'd0) && (back_win || d_start < {16'd0, window_length});
        in_cool  = (c_cool != 16'd0) && (c_count != 8'd0)
                   && (item_reg.now_seconds < c_last || d_last < {16'd0, c_cool});
        priority if (!item_reg.action_known || item_reg.param_value > item_reg.firmware_bound
                     || item_reg.param_value > c_bound)
            chk = VERDICT_BOUND;
        else if (c_lock && item_reg.source == SRC_RULE)
            chk = VERDICT_LOCKOUT;
        else if (item_reg.source == SRC_SAFETY)
            chk = VERDICT_OK;
        else if (in_cool)
            chk = VERDICT_COOLDOWN;
        else if (c_limit != 8'd0 && window_live && c_count >= c_limit)
            chk = VERDICT_RATE;
        else
            chk = VERDICT_OK;
    end

    // form the result of the current item
    logic       success_next;
    logic [2:0] verdict_next;
    always_comb
    begin
        success_next = 1'b0;
        verdict_next = VERDICT_OK;
        unique case (item_reg.kind)
            KIND_ADD:
                success_next = item_reg.action_code != 8'd0 && item_reg.action_known
                               && (rhit_reg || rfree_ok_reg) && (shit_reg || sfree_ok_reg);
            KIND_CHECK:
            begin
                if (!shit_reg)
                    verdict_next = VERDICT_UNKNOWN;
                else
                begin
                    success_next = 1'b1;
                    verdict_next = chk;
                end
            end
            KIND_RECORD, KIND_GUARDS: success_next = shit_reg;
            KIND_LOCK, KIND_REMOVE:   success_next = rhit_reg;
            default:                  success_next = 1'b0;
        endcase
    end

    assign drop_count = drop_reg;

    // load and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item_in;
        if (cmd.search)
        begin
            rhit_reg <= rhit; rhit_idx_reg <= rhit_idx;
            rfree_ok_reg <= rfree_ok; rfree_idx_reg <= rfree_idx;
        end
        else if (cmd.load)
        begin
            rhit_reg <= rhit_reg;
        end
    end

    logic srch2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            srch2_reg <= 1'b0;
        else
            srch2_reg <= cmd.search;
    end

    always_ff @(posedge clk)
    begin
        if (srch2_reg)
        begin
            shit_reg <= shit; s_reg <= shit ? s : sfree;
            sfree_ok_reg <= sfree_ok; r_reg <= r;
        end
    end

    // apply: state update and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0; row_lockout_reg <= '0; drop_reg <= '0;
            success <= 1'b0; verdict <= VERDICT_OK;
            for (int i = 0; i < DEVICE_ROWS; i++)
            begin
                row_device_reg[i] <= '0;
                for (int j = 0; j < SLOTS_PER_ROW; j++)
                begin
                    slot_action_reg[i][j] <= '0; slot_flags_reg[i][j] <= '0;
                    slot_bound_reg[i][j] <= '0; slot_cool_reg[i][j] <= '0;
                    slot_limit_reg[i][j] <= '0; slot_count_reg[i][j] <= '0;
                    slot_last_reg[i][j] <= '0; slot_start_reg[i][j] <= '0;
                end
            end
        end
        else if (cmd.apply)
        begin
            success <= success_next; verdict <= verdict_next;
            unique case (item_reg.kind)
                KIND_ADD:
                begin
                    if (item_reg.action_code != 8'd0 && item_reg.action_known)
                    begin
                        if (!rhit_reg && !rfree_ok_reg)
                            drop_reg <= drop_reg + 32'd1;
                        else
                        begin
                            if (!rhit_reg)
                            begin
                                row_valid_reg[r_reg] <= 1'b1;
                                row_device_reg[r_reg] <= item_reg.device_index;
                                row_lockout_reg[r_reg] <= 1'b0;
                            end
                            if (!shit_reg && !sfree_ok_reg)
                                drop_reg <= drop_reg + 32'd1;
                            else
                            begin
                                slot_action_reg[r_reg][s_reg] <= item_reg.action_code;
                                slot_flags_reg[r_reg][s_reg] <= item_reg.action_flags;
                                slot_bound_reg[r_reg][s_reg] <=
                                    (item_reg.param_value < item_reg.firmware_bound)
                                    ? item_reg.param_value : item_reg.firmware_bound;
                                if (!shit_reg)
                                begin
                                    slot_cool_reg[r_reg][s_reg] <= '0;
                                    slot_limit_reg[r_reg][s_reg] <= '0;
                                    slot_count_reg[r_reg][s_reg] <= '0;
                                    slot_last_reg[r_reg][s_reg] <= '0;
                                    slot_start_reg[r_reg][s_reg] <= '0;
                                end
                            end
                        end
                    end
                end
                KIND_CHECK: ;
                KIND_RECORD:
                begin
                    if (shit_reg)
                    begin
                        slot_last_reg[r_reg][s_reg] <= item_reg.now_seconds;
                        if (c_count == 8'd0
                            || (!back_win && d_start >= {16'd0, window_length}))
                        begin
                            slot_start_reg[r_reg][s_reg] <= item_reg.now_seconds;
                            slot_count_reg[r_reg][s_reg] <= 8'd1;
                        end
                        else if (c_count < COUNT_MAX)
                            slot_count_reg[r_reg][s_reg] <= c_count + 8'd1;
                    end
                end
                KIND_GUARDS:
                begin
                    if (shit_reg)
                    begin
                        slot_cool_reg[r_reg][s_reg] <= item_reg.cooldown_seconds;
                        slot_limit_reg[r_reg][s_reg] <= item_reg.hourly_limit;
                    end
                end
                KIND_LOCK:
                begin
                    if (rhit_reg)
                        row_lockout_reg[r_reg] <= item_reg.lockout_on;
                end
                KIND_REMOVE:
                begin
                    if (rhit_reg)
                    begin
                        row_valid_reg[r_reg] <= 1'b0;
                        row_device_reg[r_reg] <= '0;
                        row_lockout_reg[r_reg] <= 1'b0;
                        for (int j = 0; j < SLOTS_PER_ROW; j++)
                        begin
                            slot_action_reg[r_reg][j] <= '0; slot_flags_reg[r_reg][j] <= '0;
                            slot_bound_reg[r_reg][j] <= '0; slot_cool_reg[r_reg][j] <= '0;
                            slot_limit_reg[r_reg][j] <= '0; slot_count_reg[r_reg][j] <= '0;
                            slot_last_reg[r_reg][j] <= '0; slot_start_reg[r_reg][j] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/acg_ctrl.sv =====
`default_nettype none
module acg_ctrl
    import acg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROW    = 3'd1;
    localparam logic [2:0] ST_SLOT   = 3'd2;
    localparam logic [2:0] ST_APPLY  = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // sequence one item through search, apply and result
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_ROW;
            end
            ST_ROW:
            begin
                cmd.search = 1'b1;
                state_next = ST_SLOT;
            end
            ST_SLOT:  state_next = ST_APPLY;
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== design/actuator_command_guard_table.sv =====
// From input transaction to result valid an item passes row search, slot search and
// the update with result register; the controller handles one item at a time.
// A new item is accepted only after the result of the last one has been taken.
// Reset (rst_n, asynchronous, active low): all rows free, all slots cleared,
// drop counter zero, window_length 3600.
`default_nettype none
module actuator_command_guard_table
    import acg_pkg::*;
#(
    parameter int DEVICE_ROWS   = 8,
    parameter int SLOTS_PER_ROW = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // kind[2:0], device_index[10:3], action_code[18:11], action_known[19],
    // firmware_bound[35:20], param_value[51:36], action_flags[59:52],
    // cooldown_seconds[75:60], hourly_limit[83:76], lockout_on[84],
    // source[86:85], now_seconds[118:87], zero fill to 120
    input  wire logic [119:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // success[0], verdict[3:1], drop_count[35:4], zero fill to 40
    output logic [39:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);
    item_t       item;
    cmd_t        cmd;
    logic        success;
    logic [2:0]  verdict;
    logic [31:0] drop_count;
    logic [15:0] window_reg;

    assign item.kind             = s_tdata[2:0];
    assign item.device_index     = s_tdata[10:3];
    assign item.action_code      = s_tdata[18:11];
    assign item.action_known     = s_tdata[19];
    assign item.firmware_bound   = s_tdata[35:20];
    assign item.param_value      = s_tdata[51:36];
    assign item.action_flags     = s_tdata[59:52];
    assign item.cooldown_seconds = s_tdata[75:60];
    assign item.hourly_limit     = s_tdata[83:76];
    assign item.lockout_on       = s_tdata[84];
    assign item.source           = s_tdata[86:85];
    assign item.now_seconds      = s_tdata[118:87];

    logic unused_pad;
    assign unused_pad = s_tdata[119];

    // hold the window length register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WINDOW_DEFAULT;
        else if (cfg_valid)
            window_reg <= cfg_data;
    end

    acg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    acg_datapath #(
        .DEVICE_ROWS   (DEVICE_ROWS),
        .SLOTS_PER_ROW (SLOTS_PER_ROW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item_in       (item),
        .window_length (window_reg),
        .success       (success),
        .verdict       (verdict),
        .drop_count    (drop_count)
    );

    assign m_tdata = {4'd0, drop_count, verdict, success};
endmodule
`default_nettype wire
